### rtl/mstb_pkg.sv
`default_nettype none
package mstb_pkg;

    // time word and digit-serial slicing
    localparam int TIME_W     = 64;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = TIME_W / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

    // bank size: the slot field is 3 bits, so at most eight slots can be addressed
    localparam int NUM_TIMERS_DEF = 8;
    localparam int MAX_SLOTS      = 8;
    localparam int DONE_W         = 8;

    // duration loaded for a count-up timer
    localparam logic [TIME_W-1:0] COUNT_UP_DUR = {TIME_W{1'b1}} >> 1;

    // command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_SETUP  = 3'd1;
    localparam logic [2:0] CMD_START  = 3'd2;
    localparam logic [2:0] CMD_CANCEL = 3'd3;
    localparam logic [2:0] CMD_QUERY  = 3'd4;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [2:0]        timer_index;
        logic [TIME_W-1:0] duration;
        logic              count_up;
        logic              rearm;
    } t_in_item;

    typedef struct packed {
        logic [DONE_W-1:0] done_mask;
        logic [TIME_W-1:0] time_left;
        logic [TIME_W-1:0] check_stamp;
        logic [TIME_W-1:0] uptime_now;
        logic              accepted;
    } t_out_item;

    // control of the serial add / compare / subtract unit
    typedef struct packed {
        logic load;
        logic shift;
        logic cin;
    } t_alu_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_INC,
        S_UPD,
        S_SCAN,
        S_CMP,
        S_SWB,
        S_QRY,
        S_QWB,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

### rtl/mstb_serial_alu.sv
`default_nettype none
module mstb_serial_alu (
    input  logic                      i_clk,
    input  mstb_pkg::t_alu_ctl        i_ctl,
    input  logic [mstb_pkg::TIME_W-1:0] i_opa,
    input  logic [mstb_pkg::TIME_W-1:0] i_opb,
    input  logic [mstb_pkg::TIME_W-1:0] i_now,
    output logic [mstb_pkg::TIME_W-1:0] o_sum,
    output logic [mstb_pkg::TIME_W-1:0] o_dif,
    output logic                      o_le
);
    import mstb_pkg::*;

    localparam int SUM_W = DIGIT_W + 1;

    logic [TIME_W-1:0]  r_a;
    logic [TIME_W-1:0]  r_b;
    logic [TIME_W-1:0]  r_n;
    logic [TIME_W-1:0]  r_sum;
    logic [TIME_W-1:0]  r_dif;
    logic               r_carry;
    logic               r_borrow;
    logic               r_le;
    logic [SUM_W-1:0]   s9;
    logic [SUM_W-1:0]   d9;
    logic [DIGIT_W-1:0] s_dig;
    logic [DIGIT_W-1:0] n_dig;
    logic               n_le;

    // one digit: sum = a + b, dif = sum - now, le tracks sum <= now lsb first
    always_comb begin
        s9    = {1'b0, r_a[DIGIT_W-1:0]} + {1'b0, r_b[DIGIT_W-1:0]} + SUM_W'(r_carry);
        s_dig = s9[DIGIT_W-1:0];
        n_dig = r_n[DIGIT_W-1:0];
        d9    = {1'b0, s_dig} - {1'b0, n_dig} - SUM_W'(r_borrow);
        if (s_dig < n_dig) begin
            n_le = 1'b1;
        end else if (s_dig > n_dig) begin
            n_le = 1'b0;
        end else begin
            n_le = r_le;
        end
    end

    // operand and result shift registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a      <= i_opa;
            r_b      <= i_opb;
            r_n      <= i_now;
            r_carry  <= i_ctl.cin;
            r_borrow <= 1'b0;
            r_le     <= 1'b1;
        end else if (i_ctl.shift) begin
            r_a      <= r_a >> DIGIT_W;
            r_b      <= r_b >> DIGIT_W;
            r_n      <= r_n >> DIGIT_W;
            r_sum    <= {s_dig, r_sum[TIME_W-1:DIGIT_W]};
            r_dif    <= {d9[DIGIT_W-1:0], r_dif[TIME_W-1:DIGIT_W]};
            r_carry  <= s9[DIGIT_W];
            r_borrow <= d9[DIGIT_W];
            r_le     <= n_le;
        end
    end

    assign o_sum = r_sum;
    assign o_dif = r_dif;
    assign o_le  = r_le;

endmodule
`default_nettype wire

### rtl/millisecond_timer_bank_top.sv
`default_nettype none
// Uptime counter with a bank of software timers.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one command per transfer:
// tick, setup, start, cancel or query of a timer slot. Each command yields exactly one
// result transfer on the output channel (o_out_valid / i_out_ready / o_out_data).
// Arithmetic on the 64-bit times runs through one shared serial unit, 8 bits per cycle,
// for every 64-bit add, compare or subtract.
// Setup, start, cancel, refused or unknown commands need no arithmetic; a query runs one
// add and subtract against the uptime; a tick first adds one to the uptime, then visits
// every slot in turn and runs an add and compare only for a running slot.
// One command is processed at a time; o_in_ready is high only while idle.
// The result sits in an output register, so the next command is taken while a result
// still waits; a stalled receiver holds the block at the end of the following command.
// Reset clears the uptime, all slot times and all slot flags, and empties the output.
module millisecond_timer_bank_top #(
    parameter int NUM_TIMERS = mstb_pkg::NUM_TIMERS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mstb_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mstb_pkg::t_out_item  o_out_data
);
    import mstb_pkg::*;

    localparam int SLOTS = (NUM_TIMERS < MAX_SLOTS) ? NUM_TIMERS : MAX_SLOTS;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state             r_state;
    t_state             n_state;
    t_in_item           r_in;
    logic [TIME_W-1:0]  r_uptime;
    logic [TIME_W-1:0]  r_start [SLOTS];
    logic [TIME_W-1:0]  r_dur [SLOTS];
    logic [TIME_W-1:0]  r_chk [SLOTS];
    logic [SLOTS-1:0]   r_run;
    logic [SLOTS-1:0]   r_rsf;
    logic [SLOTS-1:0]   r_cfg;
    logic [SLOTS-1:0]   r_done;
    logic [IDX_W-1:0]   r_ptr;
    logic [DIG_CNT_W-1:0] r_dig;
    logic [TIME_W-1:0]  r_left;
    logic               r_ok;
    logic               r_ovld;
    t_out_item          r_out;

    logic [IDX_W-1:0]   slot;
    logic               slot_ok;
    logic               cmd_ok;
    logic               ptr_act;
    logic               ptr_last;
    logic               dig_last;
    logic               out_free;
    logic               in_xfer;

    // control strobes
    t_alu_ctl           alu_ctl;
    logic [IDX_W-1:0]   alu_idx;
    logic               alu_tick;
    logic               dig_clr;
    logic               dig_inc;
    logic               ptr_clr;
    logic               ptr_inc;
    logic               disp;
    logic               upd_uptime;
    logic               wr_setup;
    logic               wr_start;
    logic               wr_cancel;
    logic               swb;
    logic               qwb;
    logic               out_load;

    logic [TIME_W-1:0]  alu_opa;
    logic [TIME_W-1:0]  alu_opb;
    logic [TIME_W-1:0]  alu_sum;
    logic [TIME_W-1:0]  alu_dif;
    logic               alu_le;

    // command decode
    always_comb begin
        slot     = r_in.timer_index[IDX_W-1:0];
        slot_ok  = 32'(r_in.timer_index) < NUM_TIMERS;
        cmd_ok   = r_in.cmd <= CMD_QUERY;
        ptr_act  = r_cfg[r_ptr] & r_run[r_ptr];
        ptr_last = r_ptr == IDX_W'(SLOTS - 1);
        dig_last = r_dig == DIG_CNT_W'(NUM_DIGITS - 1);
        out_free = !r_ovld || i_out_ready;
        in_xfer  = i_in_valid && o_in_ready;
    end

    assign o_in_ready = r_state == S_IDLE;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                if (r_in.cmd == CMD_TICK) begin
                    n_state = S_INC;
                end else if (r_in.cmd == CMD_QUERY && slot_ok) begin
                    n_state = S_QRY;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_INC: begin
                if (dig_last) n_state = S_UPD;
            end
            S_UPD: n_state = S_SCAN;
            S_SCAN: begin
                if (ptr_act) begin
                    n_state = S_CMP;
                end else if (ptr_last) begin
                    n_state = S_FIN;
                end
            end
            S_CMP: begin
                if (dig_last) n_state = S_SWB;
            end
            S_SWB: n_state = ptr_last ? S_FIN : S_SCAN;
            S_QRY: begin
                if (dig_last) n_state = S_QWB;
            end
            S_QWB: n_state = S_FIN;
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        alu_ctl    = '0;
        alu_idx    = slot;
        alu_tick   = 1'b0;
        dig_clr    = 1'b0;
        dig_inc    = 1'b0;
        ptr_clr    = 1'b0;
        ptr_inc    = 1'b0;
        disp       = 1'b0;
        upd_uptime = 1'b0;
        wr_setup   = 1'b0;
        wr_start   = 1'b0;
        wr_cancel  = 1'b0;
        swb        = 1'b0;
        qwb        = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: ;
            S_DISP: begin
                disp          = 1'b1;
                dig_clr       = 1'b1;
                alu_tick      = r_in.cmd == CMD_TICK;
                alu_ctl.load  = 1'b1;
                alu_ctl.cin   = r_in.cmd == CMD_TICK;
                wr_setup      = slot_ok && r_in.cmd == CMD_SETUP;
                wr_start      = slot_ok && r_in.cmd == CMD_START && r_cfg[slot];
                wr_cancel     = slot_ok && r_in.cmd == CMD_CANCEL;
            end
            S_INC, S_CMP, S_QRY: begin
                alu_ctl.shift = 1'b1;
                dig_inc       = 1'b1;
            end
            S_UPD: begin
                upd_uptime = 1'b1;
                ptr_clr    = 1'b1;
            end
            S_SCAN: begin
                alu_idx = r_ptr;
                if (ptr_act) begin
                    alu_ctl.load = 1'b1;
                    dig_clr      = 1'b1;
                end else begin
                    ptr_inc = !ptr_last;
                end
            end
            S_SWB: begin
                swb     = 1'b1;
                ptr_inc = !ptr_last;
            end
            S_QWB: qwb = 1'b1;
            S_FIN: out_load = out_free;
            default: ;
        endcase
    end

    // operand select for the serial unit
    always_comb begin
        if (alu_tick) begin
            alu_opa = r_uptime;
            alu_opb = '0;
        end else begin
            alu_opa = r_start[alu_idx];
            alu_opb = r_dur[alu_idx];
        end
    end

    mstb_serial_alu u_alu (
        .i_clk (i_clk),
        .i_ctl (alu_ctl),
        .i_opa (alu_opa),
        .i_opb (alu_opb),
        .i_now (r_uptime),
        .o_sum (alu_sum),
        .o_dif (alu_dif),
        .o_le  (alu_le)
    );

    // control state, uptime and slot store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_uptime <= '0;
            r_run    <= '0;
            r_rsf    <= '0;
            r_cfg    <= '0;
            r_ovld   <= 1'b0;
            r_ptr    <= '0;
            r_dig    <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_start[i] <= '0;
                r_dur[i]   <= '0;
                r_chk[i]   <= '0;
            end
        end else begin
            r_state <= n_state;

            if (dig_clr) begin
                r_dig <= '0;
            end else if (dig_inc) begin
                r_dig <= r_dig + 1'b1;
            end

            if (ptr_clr) begin
                r_ptr <= '0;
            end else if (ptr_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end

            if (upd_uptime) r_uptime <= alu_sum;

            // slot commands, written at dispatch
            if (wr_setup) begin
                r_run[slot]   <= 1'b0;
                r_rsf[slot]   <= r_in.rearm;
                r_start[slot] <= '0;
                r_dur[slot]   <= r_in.count_up ? COUNT_UP_DUR : r_in.duration;
                r_chk[slot]   <= '0;
                r_cfg[slot]   <= 1'b1;
            end
            if (wr_start) begin
                r_start[slot] <= r_uptime;
                r_chk[slot]   <= r_uptime;
                r_run[slot]   <= 1'b1;
            end
            if (wr_cancel) begin
                r_run[slot]   <= 1'b0;
                r_start[slot] <= '0;
            end

            // expiry of the swept slot: restart or stop
            if (swb && alu_le) begin
                if (r_rsf[r_ptr]) begin
                    r_start[r_ptr] <= r_uptime;
                end else begin
                    r_run[r_ptr] <= 1'b0;
                end
            end

            if (qwb) r_chk[slot] <= r_uptime;

            // output register occupancy
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) r_in <= i_in_data;

        if (disp) begin
            r_done <= '0;
            r_left <= '0;
            r_ok   <= (r_in.cmd == CMD_TICK)
                   || (cmd_ok && slot_ok && !(r_in.cmd == CMD_START && !r_cfg[slot]));
        end

        if (swb && alu_le) r_done[r_ptr] <= 1'b1;

        // time left is floored at zero once the end time is reached
        if (qwb) r_left <= alu_le ? '0 : alu_dif;

        if (out_load) begin
            r_out.done_mask   <= DONE_W'(r_done);
            r_out.time_left   <= r_left;
            r_out.check_stamp <= slot_ok ? r_chk[slot] : '0;
            r_out.uptime_now  <= r_uptime;
            r_out.accepted    <= r_ok;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
